/* hdl/rxfrm_pkg.sv */
// Shared types and constants for the receive idle-timeout framer.
package rxfrm_pkg;

    // Most bytes one flush may deliver; the fill limit saturates here.
    localparam int MAX_RESULTS   = 32;
    localparam int STORE_DEPTH_D = 32;

    localparam int BYTE_W        = 8;
    localparam int IDLE_TICKS_W  = 8;
    localparam int FILL_LIMIT_W  = 6;
    localparam int CFG_DATA_W    = 8;
    localparam int CFG_INDEX_W   = 1;

    localparam logic [IDLE_TICKS_W-1:0] IDLE_TICKS_RST = 8'd32;
    localparam logic [FILL_LIMIT_W-1:0] FILL_LIMIT_RST = 6'd25;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_TICKS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILL_LIMIT = 1'b1;

    typedef enum logic {
        FR_IDLE,
        FR_FLUSH
    } fr_state_t;

endpackage

/* hdl/rx_byte_idle_timeout_framer.sv */
// Top level of the receive idle-timeout framer: byte store, idle timer and frame flush.
//
// Usage: each request on the s_ channel is either a received byte (s_opcode = byte)
// or one timer tick (s_opcode = tick). A byte is written into the frame store and
// reloads the idle countdown. Ticks count an armed countdown down; when it reaches
// zero the stored bytes leave on the m_ channel in arrival order, m_last marking
// the final one. A byte that finds the store at the fill limit is dropped and the
// frame is flushed at once with m_overflow_flush set on every byte.
// Items that cause no flush leave s_ready high. A flush reads the store through
// its single read port, one byte per cycle while m_ready does not stall; each
// byte passes the read data register and then the output register, and s_ready
// stays low until the last byte is in the output register. A stall on m_ready
// holds the read pipeline and the flush continues when the receiver takes the
// waiting byte; a finished last byte may wait there while new requests are accepted.
// Reset clears the count, the timer and the handshake state and loads the
// registers with their defaults; the store contents need no clearing.
// cfg_we writes register cfg_index (0 = idle ticks, 1 = fill limit) at once.
module rx_byte_idle_timeout_framer
    import rxfrm_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_D
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_opcode,
    input  logic [BYTE_W-1:0]       s_rx_byte,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [BYTE_W-1:0]       m_out_byte,
    output logic                    m_last,
    output logic                    m_overflow_flush
);

    localparam int LIM_MAX = (STORE_DEPTH < MAX_RESULTS) ? STORE_DEPTH : MAX_RESULTS;
    localparam int CNT_W   = $clog2(LIM_MAX + 1);
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam logic [FILL_LIMIT_W-1:0] LIM_MAX_V = FILL_LIMIT_W'(LIM_MAX);

    logic [BYTE_W-1:0] frame_mem [STORE_DEPTH];

    fr_state_t state_reg, state_next;

    logic [IDLE_TICKS_W-1:0] idle_ticks_reg;
    logic [FILL_LIMIT_W-1:0] fill_limit_reg;
    logic [CNT_W-1:0]        fill_cnt_reg, fill_cnt_next;
    logic [IDLE_TICKS_W-1:0] cd_reg, cd_next;
    logic                    armed_reg, armed_next;
    logic [CNT_W-1:0]        len_reg, len_next;
    logic                    ovf_reg, ovf_next;
    logic [CNT_W-1:0]        rd_ptr_reg;
    logic                    rd_pend_reg;
    logic                    rd_last_reg;
    logic [BYTE_W-1:0]       mem_q_reg;
    logic                    m_valid_reg;
    logic [BYTE_W-1:0]       out_byte_reg;
    logic                    out_last_reg;
    logic                    out_ovf_reg;

    logic                    in_acc;
    logic                    store_wr;
    logic                    flush_go;
    logic                    rd_en;
    logic                    load_out;
    logic                    flush_done;
    logic [FILL_LIMIT_W-1:0] eff_limit;
    logic [IDLE_TICKS_W-1:0] cd_dec;

    assign in_acc   = s_valid && s_ready;
    assign load_out = rd_pend_reg && (!m_valid_reg || m_ready);

    always_comb begin
        if (fill_limit_reg == '0) begin
            eff_limit = FILL_LIMIT_W'(1);
        end else if (fill_limit_reg > LIM_MAX_V) begin
            eff_limit = LIM_MAX_V;
        end else begin
            eff_limit = fill_limit_reg;
        end
    end

    assign cd_dec = (cd_reg != '0) ? cd_reg - IDLE_TICKS_W'(1) : cd_reg;

    // Per-item update of count and timer; a flush hands the count over as frame length.
    always_comb begin
        fill_cnt_next = fill_cnt_reg;
        cd_next       = cd_reg;
        armed_next    = armed_reg;
        len_next      = len_reg;
        ovf_next      = ovf_reg;
        store_wr      = 1'b0;
        flush_go      = 1'b0;
        if (in_acc) begin
            if (s_opcode == OP_BYTE) begin
                if (FILL_LIMIT_W'(fill_cnt_reg) >= eff_limit) begin
                    flush_go = 1'b1;
                    ovf_next = 1'b1;
                end else begin
                    store_wr      = 1'b1;
                    fill_cnt_next = fill_cnt_reg + CNT_W'(1);
                    cd_next       = (idle_ticks_reg == '0) ? IDLE_TICKS_W'(1) : idle_ticks_reg;
                    armed_next    = 1'b1;
                end
            end else if (armed_reg) begin
                cd_next = cd_dec;
                if (cd_dec == '0) begin
                    flush_go = 1'b1;
                    ovf_next = 1'b0;
                end
            end
            if (flush_go) begin
                len_next      = fill_cnt_reg;
                fill_cnt_next = '0;
                cd_next       = '0;
                armed_next    = 1'b0;
            end
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE: begin
                if (flush_go && fill_cnt_reg != '0) begin
                    state_next = FR_FLUSH;
                end
            end
            FR_FLUSH: begin
                if (flush_done) begin
                    state_next = FR_IDLE;
                end
            end
            default: begin
                state_next = FR_IDLE;
            end
        endcase
    end

    // FSM outputs.
    always_comb begin
        s_ready    = 1'b0;
        rd_en      = 1'b0;
        flush_done = 1'b0;
        case (state_reg)
            FR_IDLE: begin
                s_ready = 1'b1;
            end
            FR_FLUSH: begin
                // A read is issued only when its data slot is free or frees this cycle.
                rd_en      = (rd_ptr_reg != len_reg) && (!rd_pend_reg || load_out);
                flush_done = (rd_ptr_reg == len_reg) && !rd_pend_reg;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= FR_IDLE;
            idle_ticks_reg <= IDLE_TICKS_RST;
            fill_limit_reg <= FILL_LIMIT_RST;
            fill_cnt_reg   <= '0;
            cd_reg         <= '0;
            armed_reg      <= 1'b0;
            len_reg        <= '0;
            ovf_reg        <= 1'b0;
            rd_ptr_reg     <= '0;
            rd_pend_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_cnt_reg <= fill_cnt_next;
            cd_reg       <= cd_next;
            armed_reg    <= armed_next;
            len_reg      <= len_next;
            ovf_reg      <= ovf_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_IDLE_TICKS: idle_ticks_reg <= cfg_wdata[IDLE_TICKS_W-1:0];
                    CFG_FILL_LIMIT: fill_limit_reg <= cfg_wdata[FILL_LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (flush_go) begin
                rd_ptr_reg <= '0;
            end else if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
            end
            if (rd_en) begin
                rd_pend_reg <= 1'b1;
            end else if (load_out) begin
                rd_pend_reg <= 1'b0;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Frame store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (store_wr) begin
            frame_mem[fill_cnt_reg[ADDR_W-1:0]] <= s_rx_byte;
        end
        if (rd_en) begin
            mem_q_reg   <= frame_mem[rd_ptr_reg[ADDR_W-1:0]];
            rd_last_reg <= (rd_ptr_reg + CNT_W'(1) == len_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_byte_reg <= mem_q_reg;
            out_last_reg <= rd_last_reg;
            out_ovf_reg  <= ovf_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_byte       = out_byte_reg;
    assign m_last           = out_last_reg;
    assign m_overflow_flush = out_ovf_reg;

endmodule
